// ===== hdl/lppr_pkg.sv =====
// ----------------------------------------------------------------------------
// lppr_pkg
// Shared constants, register codes and types of the lossless pixel predictor.
// ----------------------------------------------------------------------------
package lppr_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int PIX_W    = 8;
  localparam int RW_W     = 13;
  localparam int MODE_W   = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_PRED_MODE   = 2'd0;
  localparam logic [1:0] REG_DECODE_MODE = 2'd1;
  localparam logic [1:0] REG_ROW_WIDTH   = 2'd2;

  // Predictor codes (unused codes fall back to left)
  localparam logic [MODE_W-1:0] PRED_LEFT   = 3'd0;
  localparam logic [MODE_W-1:0] PRED_ABOVE  = 3'd1;
  localparam logic [MODE_W-1:0] PRED_MEAN   = 3'd2;
  localparam logic [MODE_W-1:0] PRED_PLANE  = 3'd3;
  localparam logic [MODE_W-1:0] PRED_MED    = 3'd4;

  // Border value of the first pixel in a frame
  localparam logic signed [SAMPLE_W-1:0] PRED_FIRST = 10'sd128;

  // Position of the pixel being predicted
  typedef struct packed {
    logic first_row;
    logic col_zero;
  } pos_t;

  // One result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prediction;
    logic [PIX_W-1:0]           view;
    logic [PIX_W-1:0]           pixel;
    logic signed [SAMPLE_W-1:0] residual;
  } result_t;

endpackage

// ===== hdl/lossless_pixel_predictor_residual.sv =====
// ----------------------------------------------------------------------------
// lossless_pixel_predictor_residual
// Raster-order pixel predictor with line store; encodes pixels to residuals
// or rebuilds pixels from residuals.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: sample_value; tuser: frame_start
//  out_    | out | out_tvalid/tready  | tdata: residual, pixel, view, prediction
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  One pixel per clock sustained while the output is not stalled; output valid
//  rises once the item has passed the compute stage and output registers.
//  Line store read is issued on the input transaction and used
//  the next cycle; the line store entry written in that read cycle is forwarded.
//  Reset clears the control state; the line store needs no clearing.
//  An output stall holds the compute stage and in turn the input.
// ----------------------------------------------------------------------------
module lossless_pixel_predictor_residual (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] sample_value
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [9:0] residual_out, [17:10] pixel_out,
                                  // [25:18] residual_view, [35:26] prediction_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int COL_W = lppr_pkg::COL_W;
  localparam int CNT_W = lppr_pkg::CNT_W;

  // Configuration registers
  logic [lppr_pkg::MODE_W-1:0] pred_mode_r;
  logic                        decode_mode_r;
  logic [lppr_pkg::RW_W-1:0]   row_width_r;

  // Front position state
  logic [COL_W-1:0] col_r;
  logic             first_row_r;

  // Compute stage
  logic                                 s1_valid_r;
  logic [COL_W-1:0]                     s1_col_r;
  logic                                 s1_first_r;
  logic signed [lppr_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                                 fwd_r;
  logic [lppr_pkg::PIX_W-1:0]           fwd_pix_r;
  logic [lppr_pkg::PIX_W-1:0]           left_r;
  logic [lppr_pkg::PIX_W-1:0]           upleft_r;

  // Output register
  logic              out_valid_r;
  lppr_pkg::result_t out_res_r;

  logic              in_acc;
  logic              s1_adv;
  logic [CNT_W-1:0]  width_eff;
  logic [COL_W-1:0]  acc_col;
  logic              acc_first;
  logic [CNT_W-1:0]  col_inc;
  logic              wrap;
  logic [COL_W-1:0]  col_nxt;
  logic              first_row_nxt;
  logic [lppr_pkg::PIX_W-1:0] ram_rdata;
  logic [lppr_pkg::PIX_W-1:0] nb_b;
  lppr_pkg::pos_t    s1_pos;
  lppr_pkg::result_t res;

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

  // Effective row width, clamped to 1..MAX_WIDTH
  always_comb begin
    if (row_width_r == '0) begin
      width_eff = CNT_W'(1);
    end else if (int'(row_width_r) > lppr_pkg::MAX_WIDTH) begin
      width_eff = CNT_W'(lppr_pkg::MAX_WIDTH);
    end else begin
      width_eff = CNT_W'(row_width_r);
    end
  end

  // Position of the incoming pixel and of the one after it
  always_comb begin
    acc_col       = in_tuser ? '0 : col_r;
    acc_first     = in_tuser || first_row_r;
    col_inc       = {1'b0, acc_col} + CNT_W'(1);
    wrap          = col_inc >= width_eff;
    col_nxt       = wrap ? '0 : col_inc[COL_W-1:0];
    first_row_nxt = wrap ? 1'b0 : acc_first;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_mode_r   <= lppr_pkg::PRED_LEFT;
      decode_mode_r <= 1'b0;
      row_width_r   <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lppr_pkg::REG_PRED_MODE:   pred_mode_r   <= cfg_data[2:0];
        lppr_pkg::REG_DECODE_MODE: decode_mode_r <= cfg_data[0];
        lppr_pkg::REG_ROW_WIDTH:   row_width_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Column tracking and compute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      left_r      <= '0;
      upleft_r    <= '0;
    end else begin
      if (in_acc) begin
        col_r       <= col_nxt;
        first_row_r <= first_row_nxt;
        s1_valid_r  <= 1'b1;
        fwd_r       <= s1_adv && (s1_col_r == acc_col);
      end else if (s1_adv) begin
        s1_valid_r  <= 1'b0;
        fwd_r       <= 1'b0;
      end
      if (s1_adv) begin
        left_r   <= res.pixel;
        upleft_r <= nb_b;
      end
    end
  end

  // Compute stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r    <= acc_col;
      s1_first_r  <= acc_first;
      s1_sample_r <= $signed(in_tdata[9:0]);
      fwd_pix_r   <= res.pixel;
    end
  end

  // Line store: read on input transaction, write back from the compute stage
  lppr_ram #(
    .WIDTH(lppr_pkg::PIX_W),
    .DEPTH(lppr_pkg::MAX_WIDTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_col_r),
    .wr_data(res.pixel),
    .rd_en  (in_acc),
    .rd_addr(acc_col),
    .rd_data(ram_rdata)
  );

  // Upper neighbour, forwarded when written in the read cycle
  assign nb_b = fwd_r ? fwd_pix_r : ram_rdata;

  always_comb begin
    s1_pos.first_row = s1_first_r;
    s1_pos.col_zero  = (s1_col_r == '0);
  end

  lppr_pred u_pred (
    .nb_a       (left_r),
    .nb_b       (nb_b),
    .nb_c       (upleft_r),
    .pos        (s1_pos),
    .pred_mode  (pred_mode_r),
    .decode_mode(decode_mode_r),
    .sample     (s1_sample_r),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  // Checks
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forward flag set with empty compute stage");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled output transaction changed or dropped");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction lost before compute stage");

  a_first_pred: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_first_r && s1_col_r == '0) |->
      (res.prediction == lppr_pkg::PRED_FIRST))
    else $error("first pixel of frame not predicted as mid grey");

endmodule

// ===== hdl/lppr_ram.sv =====
// ----------------------------------------------------------------------------
// lppr_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address read and write).
// ----------------------------------------------------------------------------
module lppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lppr_pred.sv =====
// ----------------------------------------------------------------------------
// lppr_pred
// Predictor and residual datapath: picks the prediction from the left, upper
// and upper-left neighbours and forms residual, pixel and view residual.
// ----------------------------------------------------------------------------
module lppr_pred (
  input  logic [lppr_pkg::PIX_W-1:0]           nb_a,
  input  logic [lppr_pkg::PIX_W-1:0]           nb_b,
  input  logic [lppr_pkg::PIX_W-1:0]           nb_c,
  input  lppr_pkg::pos_t                       pos,
  input  logic [lppr_pkg::MODE_W-1:0]          pred_mode,
  input  logic                                 decode_mode,
  input  logic signed [lppr_pkg::SAMPLE_W-1:0] sample,
  output lppr_pkg::result_t                    res
);

  logic [8:0]         sum_ab;
  logic signed [10:0] lin;
  logic [7:0]         nb_max;
  logic [7:0]         nb_min;
  logic signed [9:0]  pred_core;
  logic signed [9:0]  pred;
  logic signed [11:0] rebuilt;
  logic [7:0]         pix;
  logic signed [9:0]  resid;
  logic signed [10:0] view_sum;

  // Neighbour arithmetic
  always_comb begin
    sum_ab = {1'b0, nb_a} + {1'b0, nb_b};
    lin    = $signed({2'b00, sum_ab}) - $signed({3'b000, nb_c});
    nb_max = (nb_a > nb_b) ? nb_a : nb_b;
    nb_min = (nb_a < nb_b) ? nb_a : nb_b;
  end

  // Predictor select
  always_comb begin
    case (pred_mode)
      lppr_pkg::PRED_ABOVE:  pred_core = $signed({2'b00, nb_b});
      lppr_pkg::PRED_MEAN:   pred_core = $signed({2'b00, sum_ab[8:1]});
      lppr_pkg::PRED_PLANE:  pred_core = lin[9:0];
      lppr_pkg::PRED_MED: begin
        if (nb_c >= nb_max) begin
          pred_core = $signed({2'b00, nb_min});
        end else if (nb_c <= nb_min) begin
          pred_core = $signed({2'b00, nb_max});
        end else begin
          pred_core = lin[9:0];
        end
      end
      default: pred_core = $signed({2'b00, nb_a});
    endcase
  end

  // Borders override the predictor
  always_comb begin
    if (pos.first_row && pos.col_zero) begin
      pred = lppr_pkg::PRED_FIRST;
    end else if (pos.first_row) begin
      pred = $signed({2'b00, nb_a});
    end else if (pos.col_zero) begin
      pred = $signed({2'b00, nb_b});
    end else begin
      pred = pred_core;
    end
  end

  // Encode or rebuild
  always_comb begin
    rebuilt = 12'(pred) + 12'(sample);
    if (decode_mode) begin
      resid = sample;
      if (rebuilt < 12'sd0) begin
        pix = 8'd0;
      end else if (rebuilt > 12'sd255) begin
        pix = 8'd255;
      end else begin
        pix = rebuilt[7:0];
      end
    end else begin
      if (sample < 10'sd0) begin
        pix = 8'd0;
      end else if (sample > 10'sd255) begin
        pix = 8'd255;
      end else begin
        pix = sample[7:0];
      end
      resid = $signed({2'b00, pix}) - pred;
    end
  end

  // View residual, offset by 128 and clamped
  always_comb begin
    view_sum = 11'(resid) + 11'sd128;
    res.prediction = pred;
    res.residual   = resid;
    res.pixel      = pix;
    if (view_sum < 11'sd0) begin
      res.view = 8'd0;
    end else if (view_sum > 11'sd255) begin
      res.view = 8'd255;
    end else begin
      res.view = view_sum[7:0];
    end
  end

endmodule
